@@ rtl/sed_pkg.sv @@
// Shared types and constants for the string escape decoder.
`timescale 1ns / 1ps

package sed_pkg;

  localparam int          QUEUE_DEPTH = 4;
  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        error_flag;
    logic [15:0] error_position;
  } res_t;

  // One decoded input word: zero to two result words.
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/sed_if.sv @@
// Handshake channel interfaces of the string escape decoder.
`timescale 1ns / 1ps

interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;
  modport source (output valid, char_in, last_char, input ready);
  modport sink (input valid, char_in, last_char, output ready);
endinterface

interface sed_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        error_flag;
  logic [15:0] error_position;
  logic        last_out;
  modport source (output valid, out_byte, error_flag, error_position, last_out, input ready);
  modport sink (input valid, out_byte, error_flag, error_position, last_out, output ready);
endinterface

interface sed_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/sed_front.sv @@
// Front end: accepts characters, runs the escape state machine, queues results.
`timescale 1ns / 1ps

module sed_front (
  input  logic             clk,
  input  logic             rst,
  sed_in_if.sink           in_ch,
  sed_cfg_if.sink          cfg_ch,
  input  sed_pkg::q_stat_t q_stat,
  output logic             push,
  output sed_pkg::entry_t  push_entry
);

  localparam logic [2:0] MODE_PLAIN = 3'd0;
  localparam logic [2:0] MODE_ESC   = 3'd1;
  localparam logic [2:0] MODE_HEX0  = 3'd2;
  localparam logic [2:0] MODE_HEX1  = 3'd3;
  localparam logic [2:0] MODE_OCT1  = 3'd4;
  localparam logic [2:0] MODE_OCT2  = 3'd5;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] POS_MAX_B = 8'hFF;

  // {valid, value} of a named escape letter
  function automatic logic [8:0] named_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_BSLASH: r = {1'b1, 8'h5C};
      CH_QUOTE:  r = {1'b1, 8'h22};
      CH_N:      r = {1'b1, 8'h0A};
      CH_T:      r = {1'b1, 8'h09};
      CH_R:      r = {1'b1, 8'h0D};
      CH_LA:     r = {1'b1, 8'h07};
      CH_B:      r = {1'b1, 8'h08};
      CH_LF:     r = {1'b1, 8'h0C};
      default:   r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

  logic [2:0]  mode;
  logic [7:0]  acc;
  logic [15:0] emitted;
  logic [15:0] position;
  logic        halted;
  logic [15:0] output_limit;

  logic        accept;
  logic        is_bs, hex_ok, oct_ok, end_run;
  logic [3:0]  hex_val;
  logic [2:0]  oct_d;
  logic [8:0]  named;
  logic [2:0]  mode_mid;
  logic [7:0]  acc_mid;
  logic [2:0]  act_byte, act_err;
  logic [7:0]  act_val [3];
  logic [1:0]  n_res;
  sed_pkg::res_t r0, r1;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_stat.full;
  assign accept       = in_ch.valid && in_ch.ready;

  // character classes
  always_comb begin
    is_bs   = (in_ch.char_in == CH_BSLASH);
    oct_ok  = (in_ch.char_in >= CH_ZERO) && (in_ch.char_in <= CH_SEVEN);
    oct_d   = in_ch.char_in[2:0];
    named   = named_escape(in_ch.char_in);
    hex_ok  = 1'b0;
    hex_val = 4'd0;
    if ((in_ch.char_in >= CH_ZERO) && (in_ch.char_in <= CH_NINE)) begin
      hex_ok  = 1'b1;
      hex_val = in_ch.char_in[3:0];
    end else if (((in_ch.char_in >= CH_LA) && (in_ch.char_in <= CH_LF)) ||
                 ((in_ch.char_in >= CH_UA) && (in_ch.char_in <= CH_UF))) begin
      hex_ok  = 1'b1;
      hex_val = in_ch.char_in[3:0] + 4'd9;
    end
  end

  // escape decode: up to three candidate actions in model order
  always_comb begin
    mode_mid = mode;
    acc_mid  = acc;
    end_run  = 1'b0;
    act_byte = '0;
    act_err  = '0;
    for (int k = 0; k < 3; k++) begin
      act_val[k] = 8'd0;
    end
    case (mode)
      MODE_ESC: begin
        if (in_ch.char_in == CH_X) begin
          mode_mid = MODE_HEX0;
        end else if (oct_ok) begin
          acc_mid  = {5'd0, oct_d};
          mode_mid = MODE_OCT1;
        end else begin
          mode_mid = MODE_PLAIN;
          if (named[8]) begin
            act_byte[0] = 1'b1;
            act_val[0]  = named[7:0];
          end else begin
            act_err[0] = 1'b1;
          end
        end
      end
      MODE_HEX0: begin
        if (!hex_ok) begin
          mode_mid   = MODE_PLAIN;
          act_err[0] = 1'b1;
        end else begin
          acc_mid  = {4'd0, hex_val};
          mode_mid = MODE_HEX1;
        end
      end
      MODE_HEX1: begin
        if (!hex_ok) begin
          end_run = 1'b1;
        end else begin
          mode_mid    = MODE_PLAIN;
          act_byte[0] = 1'b1;
          act_val[0]  = {acc[3:0], hex_val};
          acc_mid     = 8'd0;
        end
      end
      MODE_OCT1: begin
        if (oct_ok) begin
          acc_mid  = {acc[4:0], oct_d};
          mode_mid = MODE_OCT2;
        end else begin
          end_run = 1'b1;
        end
      end
      MODE_OCT2: begin
        if (oct_ok) begin
          mode_mid    = MODE_PLAIN;
          act_byte[0] = 1'b1;
          act_val[0]  = {acc[4:0], oct_d};
          acc_mid     = 8'd0;
        end else begin
          end_run = 1'b1;
        end
      end
      default: begin
        if (is_bs) begin
          mode_mid = MODE_ESC;
        end else begin
          mode_mid    = MODE_PLAIN;
          act_byte[0] = 1'b1;
          act_val[0]  = in_ch.char_in;
        end
      end
    endcase
    // digit run closed by a non-digit: flush value, then treat char as text
    if (end_run) begin
      act_byte[0] = 1'b1;
      act_val[0]  = acc;
      acc_mid     = 8'd0;
      if (is_bs) begin
        mode_mid = MODE_ESC;
      end else begin
        mode_mid    = MODE_PLAIN;
        act_byte[1] = 1'b1;
        act_val[1]  = in_ch.char_in;
      end
    end
    // end of string flush
    if (in_ch.last_char) begin
      case (mode_mid)
        MODE_HEX1, MODE_OCT1, MODE_OCT2: begin
          act_byte[2] = 1'b1;
          act_val[2]  = acc_mid;
        end
        MODE_ESC, MODE_HEX0: begin
          act_err[2] = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // emit chain: limit check and halt propagate through the actions in order,
  // surviving results are captured as they go
  logic [15:0] cnt_walk;
  logic        h_walk;
  always_comb begin
    h_walk   = halted;
    cnt_walk = emitted;
    n_res    = 2'd0;
    r0       = '0;
    r1       = '0;
    for (int k = 0; k < 3; k++) begin
      if (!h_walk && act_err[k]) begin
        if (n_res == 2'd0) begin
          r0 = '{out_byte: 8'd0, error_flag: 1'b1, error_position: position};
        end else begin
          r1 = '{out_byte: 8'd0, error_flag: 1'b1, error_position: position};
        end
        n_res  = n_res + 2'd1;
        h_walk = 1'b1;
      end else if (!h_walk && act_byte[k]) begin
        if (cnt_walk >= output_limit) begin
          h_walk = 1'b1;
        end else begin
          if (n_res == 2'd0) begin
            r0 = '{out_byte: act_val[k], error_flag: 1'b0, error_position: 16'd0};
          end else begin
            r1 = '{out_byte: act_val[k], error_flag: 1'b0, error_position: 16'd0};
          end
          n_res    = n_res + 2'd1;
          cnt_walk = cnt_walk + 16'd1;
          h_walk   = (cnt_walk >= output_limit);
        end
      end
    end
  end

  assign push       = accept && (n_res != 2'd0);
  assign push_entry = '{count: n_res, res0: r0, res1: r1};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_PLAIN;
      acc          <= 8'd0;
      emitted      <= 16'd0;
      position     <= 16'd0;
      halted       <= 1'b0;
      output_limit <= sed_pkg::LIMIT_RESET;
    end else begin
      if (cfg_ch.valid) begin
        output_limit <= cfg_ch.data;
      end
      if (accept) begin
        if (in_ch.last_char) begin
          mode     <= MODE_PLAIN;
          acc      <= 8'd0;
          emitted  <= 16'd0;
          position <= 16'd0;
          halted   <= 1'b0;
        end else begin
          if (!halted) begin
            mode <= mode_mid;
            acc  <= acc_mid;
          end
          emitted <= cnt_walk;
          halted  <= h_walk;
          if (position != {POS_MAX_B, POS_MAX_B}) begin
            position <= position + 16'd1;
          end
        end
      end
    end
  end

endmodule

@@ rtl/sed_queue.sv @@
// Small FIFO of decoded entries between front and back ends.
`timescale 1ns / 1ps

module sed_queue #(
  parameter int DEPTH = sed_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sed_pkg::entry_t  push_entry,
  input  logic             pop,
  output sed_pkg::entry_t  head,
  output sed_pkg::q_stat_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sed_pkg::entry_t store [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;
  logic            do_push, do_pop;

  assign q_stat.full  = (fill == CW'(DEPTH));
  assign q_stat.empty = (fill == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

@@ rtl/sed_back.sv @@
// Back end: splits queued entries into output words and marks the last one.
`timescale 1ns / 1ps

module sed_back (
  input  logic             clk,
  input  logic             rst,
  input  sed_pkg::entry_t  head,
  input  sed_pkg::q_stat_t q_stat,
  output logic             pop,
  sed_out_if.source        out_ch
);

  logic          sub;
  logic          fire;
  logic          at_last;
  sed_pkg::res_t sel;

  assign sel     = sub ? head.res1 : head.res0;
  assign at_last = sub || (head.count == 2'd1);
  assign fire    = out_ch.valid && out_ch.ready;
  assign pop     = fire && at_last;

  assign out_ch.valid          = !q_stat.empty;
  assign out_ch.out_byte       = sel.out_byte;
  assign out_ch.error_flag     = sel.error_flag;
  assign out_ch.error_position = sel.error_position;
  assign out_ch.last_out       = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (fire) begin
      sub <= !at_last;
    end
  end

endmodule

@@ rtl/string_escape_decoder_unit.sv @@
// Top level of the string escape decoder: front end, entry queue, back end.
//
//  channel  dir  word                                          handshake
//  in_ch    in   char_in[7:0], last_char                       valid/ready
//  out_ch   out  out_byte[7:0], error_flag, error_position,    valid/ready
//                last_out
//  cfg_ch   in   data[15:0] -> output_limit                    valid/ready
//
// One input word is taken per cycle while the queue has room; its results
// are registered in the entry queue and then shown on out_ch.
// The back end sends one output word per cycle while out_ch is ready, so
// an input word that decodes to two bytes (closed digit run plus the closing
// character) goes out as two words; QUEUE_DEPTH entries absorb such bursts.
// Synchronous active-high reset clears the decoder state, the queue and
// sets output_limit to 65535. cfg_ch is always ready.
// A stall on out_ch backs up into the queue; in_ch.ready drops only when
// the queue is full.
`timescale 1ns / 1ps

module string_escape_decoder_unit #(
  parameter int QUEUE_DEPTH = sed_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  sed_in_if.sink    in_ch,
  sed_cfg_if.sink   cfg_ch,
  sed_out_if.source out_ch
);

  sed_pkg::q_stat_t q_stat;
  sed_pkg::entry_t  push_entry;
  sed_pkg::entry_t  head;
  logic             push;
  logic             pop;

  // decode: escape state machine, limit and halt handling
  sed_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples decode from output stalls
  sed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // word sequencing onto out_ch
  sed_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

@@ bench/tb_string_escape_decoder_unit.sv @@
// Self-checking testbench for the string escape decoder: directed and random strings, checked word by word.
`timescale 1ns / 1ps

module tb_string_escape_decoder_unit;

  // ---------------------------------------------------------------------------
  // Constants
  // ---------------------------------------------------------------------------
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_X      = "x";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_SEVEN  = "7";

  // Words that cause no result may still be in flight when the output side
  // looks drained; wait this long before touching the register.
  localparam int SETTLE_CYCLES  = 2 * sed_pkg::QUEUE_DEPTH + 8;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int PHASE_WORDS    = 75;    // input words per random phase
  localparam int MAX_REPORTS    = 40;

  // Decoder modes, mirrored from the block's behavior.
  typedef enum logic [2:0] {
    M_PLAIN, M_ESC, M_HEX0, M_HEX1, M_OCT1, M_OCT2
  } esc_mode_e;

  // Receiver stall patterns.
  typedef enum logic [1:0] {RX_FULL, RX_OPEN, RX_HALF, RX_SLOW} rx_mode_e;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        error_flag;
    logic [15:0] error_position;
    logic        last_out;
  } dec_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst;

  sed_in_if  in_if ();
  sed_cfg_if cfg_if ();
  sed_out_if out_if ();

  string_escape_decoder_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .cfg_ch (cfg_if),
    .out_ch (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the decoder and its register
  // ---------------------------------------------------------------------------
  esc_mode_e   mode_q;
  logic [7:0]  acc_q;       // digit accumulator
  logic [15:0] sent_q;      // bytes emitted in this string
  logic [15:0] pos_q;       // input index in this string, saturating
  logic [15:0] limit_q;     // output_limit as written
  bit          halted_q;

  dec_word_t   step_q[$];   // results of the word being decoded
  dec_word_t   decoded_q[$];// expected output words, oldest first
  char_word_t  char_q[$];   // input words waiting to be driven

  int mismatches;
  int reports;

  // Stimulus / idling knobs shared with the clocked processes
  int gap_max;
  int hold_asked;
  int hold_served;

  function automatic void clear_string();
    mode_q   = M_PLAIN;
    acc_q    = 8'd0;
    sent_q   = 16'd0;
    pos_q    = 16'd0;
    halted_q = 1'b0;
  endfunction

  // Byte result, subject to the output limit: halts before emitting when the
  // limit is already reached, and right after the emit that reaches it.
  function automatic void push_byte(logic [7:0] b);
    if (halted_q) return;
    if (sent_q >= limit_q) begin
      halted_q = 1'b1;
      return;
    end
    step_q.push_back('{b, 1'b0, 16'd0, 1'b0});
    sent_q = sent_q + 16'd1;
    if (sent_q >= limit_q) halted_q = 1'b1;
  endfunction

  function automatic void push_error(logic [15:0] at);
    if (halted_q) return;
    step_q.push_back('{8'd0, 1'b1, at, 1'b0});
    halted_q = 1'b1;
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic bit is_oct(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_SEVEN;
  endfunction

  function automatic int named_val(logic [7:0] c);
    case (c)
      CH_BSLASH: return 'h5C;
      CH_QUOTE:  return 'h22;
      "n":       return 'h0A;
      "t":       return 'h09;
      "r":       return 'h0D;
      "a":       return 'h07;
      "b":       return 'h08;
      "f":       return 'h0C;
      default:   return -1;
    endcase
  endfunction

  function automatic void plain_char(logic [7:0] c);
    if (c == CH_BSLASH) mode_q = M_ESC;
    else push_byte(c);
  endfunction

  // A digit run closed by a non-digit: emit the run, then the closer counts
  // as ordinary text (so one word can give two bytes).
  function automatic void end_run(logic [7:0] c);
    push_byte(acc_q);
    acc_q  = 8'd0;
    mode_q = M_PLAIN;
    if (!halted_q) plain_char(c);
  endfunction

  function automatic void decode_mode(logic [7:0] c, logic [15:0] at);
    int v;
    case (mode_q)
      M_ESC: begin
        if (c == CH_X) begin
          mode_q = M_HEX0;
        end else if (is_oct(c)) begin
          acc_q  = c - CH_ZERO;
          mode_q = M_OCT1;
        end else begin
          mode_q = M_PLAIN;
          v = named_val(c);
          if (v < 0) push_error(at);
          else push_byte(v[7:0]);
        end
      end
      M_HEX0: begin
        // bad first hex digit is an error at that character
        v = hex_val(c);
        if (v < 0) begin
          mode_q = M_PLAIN;
          push_error(at);
        end else begin
          acc_q  = v[7:0];
          mode_q = M_HEX1;
        end
      end
      M_HEX1: begin
        v = hex_val(c);
        if (v < 0) begin
          end_run(c);
        end else begin
          mode_q = M_PLAIN;
          push_byte({acc_q[3:0], v[3:0]});
          acc_q = 8'd0;
        end
      end
      M_OCT1: begin
        if (is_oct(c)) begin
          acc_q  = {acc_q[4:0], 3'b000} + (c - CH_ZERO);
          mode_q = M_OCT2;
        end else begin
          end_run(c);
        end
      end
      M_OCT2: begin
        // third octal digit: value truncated to 8 bits
        if (is_oct(c)) begin
          mode_q = M_PLAIN;
          push_byte({acc_q[4:0], 3'b000} + (c - CH_ZERO));
          acc_q = 8'd0;
        end else begin
          end_run(c);
        end
      end
      default: begin
        mode_q = M_PLAIN;
        plain_char(c);
      end
    endcase
  endfunction

  // Expected results of one accepted input word, appended to decoded_q.
  function automatic void decode_char(logic [7:0] c, logic last);
    logic [15:0] at;
    dec_word_t   w;
    at = pos_q;
    if (pos_q != 16'hFFFF) pos_q = pos_q + 16'd1;
    step_q.delete();
    if (!halted_q) begin
      decode_mode(c, at);
      // end of string: flush an open digit run, flag a bare \ or \x
      if (last && !halted_q) begin
        if (mode_q == M_HEX1 || mode_q == M_OCT1 || mode_q == M_OCT2)
          push_byte(acc_q);
        else if (mode_q == M_ESC || mode_q == M_HEX0)
          push_error(at);
      end
    end
    // a final word resets the string even when halted
    if (last) clear_string();
    for (int i = 0; i < step_q.size(); i++) begin
      w = step_q[i];
      w.last_out = (i == step_q.size() - 1);
      decoded_q.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_char(logic [7:0] c, logic last);
    char_q.push_back('{c, last});
  endtask

  // One string literal built from tokens; mostly well formed escapes with
  // random content, some noise, and now and then an escape left open at the end.
  task automatic add_string(int n_tokens);
    logic [7:0] s[$];
    logic [7:0] c;
    string      hexd;
    string      named;
    int         kind;
    int         n;
    hexd  = "0123456789abcdefABCDEF";
    named = "\\\"ntrabf";
    for (int k = 0; k < n_tokens; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_BSLASH) c = "A";
        s.push_back(c);
      end else if (kind < 50) begin
        s.push_back(CH_BSLASH);
        s.push_back(named.getc($urandom_range(0, 7)));
      end else if (kind < 68) begin
        s.push_back(CH_BSLASH);
        s.push_back(CH_X);
        n = $urandom_range(1, 2);
        repeat (n) s.push_back(hexd.getc($urandom_range(0, 21)));
      end else if (kind < 88) begin
        s.push_back(CH_BSLASH);
        n = $urandom_range(1, 3);
        repeat (n) s.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
      end else if (kind < 95) begin
        // escape with an arbitrary character: often invalid
        s.push_back(CH_BSLASH);
        s.push_back(8'($urandom_range(0, 255)));
      end else begin
        s.push_back(CH_BSLASH);
        s.push_back(CH_X);
        s.push_back(8'($urandom_range(0, 255)));
      end
    end
    // broken tail: bare backslash or bare \x as the final character
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      s.push_back(CH_BSLASH);
    end else if (kind == 1) begin
      s.push_back(CH_BSLASH);
      s.push_back(CH_X);
    end
    for (int i = 0; i < s.size(); i++) add_char(s[i], i == s.size() - 1);
  endtask

  task automatic add_phase(int words);
    while (char_q.size() < words) begin
      if ($urandom_range(0, 9) == 0) add_string($urandom_range(10, 40));
      else add_string($urandom_range(1, 10));
    end
  endtask

  // Block is idle: nothing left to drive, nothing in flight, nothing expected.
  task automatic wait_drained();
    do begin
      while (char_q.size() != 0 || in_if.valid || decoded_q.size() != 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (char_q.size() != 0 || in_if.valid || decoded_q.size() != 0);
  endtask

  task automatic write_limit(logic [15:0] v);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    limit_q = v;
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin : drive_in
    char_word_t w;
    logic       offer;
    if (rst) begin
      in_if.valid <= 1'b0;
      burst_left  = 0;
      gap_left    = 0;
    end else begin
      if (in_if.valid && in_if.ready) decode_char(in_if.char_in, in_if.last_char);
      // slot is free when nothing is offered or the offer was just taken
      if (!in_if.valid || in_if.ready) begin
        offer = 1'b0;
        if (burst_left == 0 && gap_left > 0) gap_left--;
        else if (burst_left == 0) burst_left = $urandom_range(1, 16);
        if (burst_left > 0 && char_q.size() > 0) begin
          w = char_q.pop_front();
          in_if.char_in   <= w.ch;
          in_if.last_char <= w.last;
          offer = 1'b1;
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(0, gap_max);
        end
        in_if.valid <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor and receiver stall pattern
  // ---------------------------------------------------------------------------
  rx_mode_e rx_mode;
  int       rx_left;
  int       hold_left;

  always @(posedge clk) begin : watch_out
    dec_word_t got;
    dec_word_t want;
    logic      rdy;
    if (rst) begin
      out_if.ready <= 1'b0;
      rx_mode   = RX_FULL;
      rx_left   = 0;
      hold_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.out_byte, out_if.error_flag, out_if.error_position, out_if.last_out};
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: unexpected word: expected none, got byte %h err %b pos %0d last %b",
                     $time, got.out_byte, got.error_flag, got.error_position, got.last_out);
          end
        end else begin
          want = decoded_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (reports < MAX_REPORTS) begin
              reports++;
              $display("%0t: mismatch: expected %h/%b/%0d/%b, got %h/%b/%0d/%b",
                       $time, want.out_byte, want.error_flag, want.error_position,
                       want.last_out, got.out_byte, got.error_flag, got.error_position,
                       got.last_out);
            end
          end
        end
      end
      // a new stall pattern is drawn when the current one runs out
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      if (hold_asked != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          RX_HALF: rdy = ($urandom_range(0, 1) == 1);
          RX_SLOW: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = 1'b1;
        endcase
      end
      out_if.ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no handshake of any kind for too long ends the run
  // ---------------------------------------------------------------------------
  int idle_cycles;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no handshake for %0d cycles, %0d words still expected",
                 $time, idle_cycles, decoded_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed strings, limit sweep
  // ---------------------------------------------------------------------------
  initial begin : run
    logic [15:0] limits[8];
    in_if.valid     = 1'b0;
    in_if.char_in   = 8'd0;
    in_if.last_char = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = 16'd0;
    out_if.ready    = 1'b0;
    mismatches  = 0;
    reports     = 0;
    gap_max     = 8;
    hold_asked  = 0;
    hold_served = 0;
    limit_q     = sed_pkg::LIMIT_RESET;
    clear_string();

    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed, at the reset limit.
    // extremes, \xAf, octal run closed by a letter (two bytes), \777 truncated
    add_char(8'h00, 1'b0);
    add_char(CH_BSLASH, 1'b0); add_char(CH_X, 1'b0); add_char("A", 1'b0);
    add_char("f", 1'b0);
    add_char(CH_BSLASH, 1'b0); add_char("1", 1'b0); add_char("2", 1'b0);
    add_char("g", 1'b0);
    add_char(CH_BSLASH, 1'b0); add_char("7", 1'b0); add_char("7", 1'b0);
    add_char("7", 1'b0);
    add_char(8'hFF, 1'b1);
    // unknown named escape
    add_char(CH_BSLASH, 1'b0); add_char("q", 1'b1);
    // bad first hex digit
    add_char(CH_BSLASH, 1'b0); add_char(CH_X, 1'b0); add_char("g", 1'b1);
    // bare \x at the end
    add_char(CH_BSLASH, 1'b0); add_char(CH_X, 1'b1);
    // digit run flushed at the end
    add_char(CH_BSLASH, 1'b0); add_char("5", 1'b1);
    // hex run closed by a backslash that is itself left bare: byte then error
    add_char(CH_BSLASH, 1'b0); add_char(CH_X, 1'b0); add_char("4", 1'b0);
    add_char(CH_BSLASH, 1'b1);

    // Limit sweep: zero halts at once, tiny limits halt mid string.
    limits = '{16'hFFFF, 16'd0, 16'd1, 16'd3, 16'($urandom_range(2, 12)),
               16'hFFFF, 16'($urandom_range(0, 65535)), 16'hFFFF};
    foreach (limits[i]) begin
      write_limit(limits[i]);
      gap_max = (i == 5) ? 0 : 12;       // one phase with a sender that never idles
      if (i == 7) hold_asked++;          // receiver holds off while input keeps coming
      add_phase(PHASE_WORDS);
    end

    wait_drained();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
